### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### rtl/core/ngt_pkg.sv
// ----------------------------------------------------------------------------
// ngt_pkg
// Types, character codes and helpers of the group tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ngt_pkg;

  // scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_PAREN  = 3'd2,
    MODE_CURLY  = 3'd3,
    MODE_SQUARE = 3'd4,
    MODE_DQ     = 3'd5,
    MODE_SQ     = 3'd6
  } scan_mode_e;

  // token kinds as seen on the result channel
  typedef enum logic [2:0] {
    KIND_WORD   = 3'd0,
    KIND_PAREN  = 3'd1,
    KIND_CURLY  = 3'd2,
    KIND_SQUARE = 3'd3,
    KIND_DQUOTE = 3'd4,
    KIND_SQUOTE = 3'd5
  } token_kind_e;

  // character codes
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // result beat payload
  typedef struct packed {
    logic [7:0]  char_out;
    logic        has_char;
    logic        token_start;
    logic        token_end;
    token_kind_e token_kind;
    logic        unterminated;
    logic        string_end;
  } result_t;

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // kind of the token opened by a character outside any token
  function automatic token_kind_e kind_of_opener(input logic [7:0] c);
    token_kind_e k;
    case (c)
      CH_LPAREN:  k = KIND_PAREN;
      CH_LCURLY:  k = KIND_CURLY;
      CH_LSQUARE: k = KIND_SQUARE;
      CH_DQUOTE:  k = KIND_DQUOTE;
      CH_SQUOTE:  k = KIND_SQUOTE;
      default:    k = KIND_WORD;
    endcase
    return k;
  endfunction

  // mode entered for a token kind
  function automatic scan_mode_e mode_of_kind(input token_kind_e k);
    scan_mode_e m;
    case (k)
      KIND_WORD:   m = MODE_WORD;
      KIND_PAREN:  m = MODE_PAREN;
      KIND_CURLY:  m = MODE_CURLY;
      KIND_SQUARE: m = MODE_SQUARE;
      KIND_DQUOTE: m = MODE_DQ;
      KIND_SQUOTE: m = MODE_SQ;
      default:     m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/ngt_in_if.sv
// ----------------------------------------------------------------------------
// ngt_in_if
// Character channel into the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ngt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, output char_in, output last, input ready);
  modport sink (input valid, input char_in, input last, output ready);
endinterface

### rtl/core/ngt_out_if.sv
// ----------------------------------------------------------------------------
// ngt_out_if
// Tagged token character channel out of the tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ngt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       has_char;
  logic       token_start;
  logic       token_end;
  logic [2:0] token_kind;
  logic       unterminated;
  logic       string_end;

  modport source (
    output valid, output char_out, output has_char, output token_start,
    output token_end, output token_kind, output unterminated, output string_end,
    input ready
  );
  modport sink (
    input valid, input char_out, input has_char, input token_start,
    input token_end, input token_kind, input unterminated, input string_end,
    output ready
  );
endinterface

### rtl/core/nested_group_tokenizer.sv
// ----------------------------------------------------------------------------
// nested_group_tokenizer
// Splits a character stream into words, bracket groups and quoted strings
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  beat
//  in_i     in   char_in, last                            one character
//  out_o    out  char_out, has_char, token_start,         zero or one per
//                token_end, token_kind, unterminated,     input character
//                string_end
//
//  one character per cycle while in_i is ready; its result is registered and shows in the cycle after acceptance
//  state (mode, depth, backslash flag) updates in the cycle a character is taken
//  a single result register decouples the sides; in_i stalls only while it is full
//  and out_o is not ready
//  reset is asynchronous, active low, and leaves the scanner between tokens
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nested_group_tokenizer #(
  parameter int DEPTH_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ngt_in_if.sink    in_i,
  ngt_out_if.source out_o
);

  localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);

  ngt_pkg::scan_mode_e   mode_q, mode_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  bs_q, bs_d;
  logic                  out_valid_q;
  ngt_pkg::result_t      res_q, res_d;

  logic                  in_acc;
  logic                  emit;
  logic                  closed;
  logic                  ws;
  logic [7:0]            c;
  logic [7:0]            open_ch, close_ch, quote_ch;
  logic [DEPTH_BITS-1:0] dec_depth;
  ngt_pkg::token_kind_e  kind;

  // handshake: take a beat unless a result waits and is not drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign c  = in_i.char_in;
  assign ws = ngt_pkg::is_space(c);

  // per-character scan step
  always_comb begin
    mode_d    = mode_q;
    depth_d   = depth_q;
    emit      = 1'b1;
    closed    = 1'b0;
    kind      = ngt_pkg::KIND_WORD;
    open_ch   = ngt_pkg::CH_LPAREN;
    close_ch  = ngt_pkg::CH_RPAREN;
    quote_ch  = ngt_pkg::CH_DQUOTE;
    dec_depth = depth_q;
    res_d.char_out     = c;
    res_d.has_char     = 1'b1;
    res_d.token_start  = 1'b0;
    res_d.token_end    = 1'b0;
    res_d.unterminated = 1'b0;
    res_d.string_end   = in_i.last;

    case (mode_q)
      ngt_pkg::MODE_WORD: begin
        if (ws) begin
          res_d.has_char  = 1'b0;
          res_d.token_end = 1'b1;
          mode_d          = ngt_pkg::MODE_IDLE;
        end else begin
          res_d.token_end = in_i.last;
        end
      end
      ngt_pkg::MODE_PAREN, ngt_pkg::MODE_CURLY, ngt_pkg::MODE_SQUARE: begin
        case (mode_q)
          ngt_pkg::MODE_CURLY: begin
            kind     = ngt_pkg::KIND_CURLY;
            open_ch  = ngt_pkg::CH_LCURLY;
            close_ch = ngt_pkg::CH_RCURLY;
          end
          ngt_pkg::MODE_SQUARE: begin
            kind     = ngt_pkg::KIND_SQUARE;
            open_ch  = ngt_pkg::CH_LSQUARE;
            close_ch = ngt_pkg::CH_RSQUARE;
          end
          default: begin
            kind     = ngt_pkg::KIND_PAREN;
            open_ch  = ngt_pkg::CH_LPAREN;
            close_ch = ngt_pkg::CH_RPAREN;
          end
        endcase
        // escaped brackets do not count
        if (!bs_q) begin
          if (c == open_ch) begin
            if (depth_q != DepthMax) depth_d = depth_q + DepthOne;
          end else if (c == close_ch) begin
            if (depth_q != '0) dec_depth = depth_q - DepthOne;
            depth_d = dec_depth;
            closed  = (dec_depth == '0);
          end
        end
        res_d.token_end    = closed || in_i.last;
        res_d.unterminated = !closed && in_i.last;
        if (closed) begin
          mode_d  = ngt_pkg::MODE_IDLE;
          depth_d = '0;
        end
      end
      ngt_pkg::MODE_DQ, ngt_pkg::MODE_SQ: begin
        if (mode_q == ngt_pkg::MODE_SQ) begin
          kind     = ngt_pkg::KIND_SQUOTE;
          quote_ch = ngt_pkg::CH_SQUOTE;
        end else begin
          kind     = ngt_pkg::KIND_DQUOTE;
          quote_ch = ngt_pkg::CH_DQUOTE;
        end
        closed             = (c == quote_ch);
        res_d.token_end    = closed || in_i.last;
        res_d.unterminated = !closed && in_i.last;
        if (closed) mode_d = ngt_pkg::MODE_IDLE;
      end
      default: begin
        // between tokens; whitespace is dropped unless it ends the string
        if (ws) begin
          res_d.has_char = 1'b0;
          emit           = in_i.last;
        end else begin
          kind               = ngt_pkg::kind_of_opener(c);
          mode_d             = ngt_pkg::mode_of_kind(kind);
          depth_d            = (kind == ngt_pkg::KIND_PAREN || kind == ngt_pkg::KIND_CURLY ||
                                kind == ngt_pkg::KIND_SQUARE) ? DepthOne : '0;
          res_d.token_start  = 1'b1;
          res_d.token_end    = in_i.last;
          res_d.unterminated = in_i.last && (kind != ngt_pkg::KIND_WORD);
        end
      end
    endcase

    res_d.token_kind = kind;
    if (!res_d.has_char) res_d.char_out = '0;

    bs_d = (c == ngt_pkg::CH_BSLASH);
    // end of string returns everything to reset
    if (in_i.last) begin
      mode_d  = ngt_pkg::MODE_IDLE;
      depth_d = '0;
      bs_d    = 1'b0;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ngt_pkg::MODE_IDLE;
      depth_q <= '0;
      bs_q    <= 1'b0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      bs_q    <= bs_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= emit;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.char_out     = res_q.char_out;
  assign out_o.has_char     = res_q.has_char;
  assign out_o.token_start  = res_q.token_start;
  assign out_o.token_end    = res_q.token_end;
  assign out_o.token_kind   = res_q.token_kind;
  assign out_o.unterminated = res_q.unterminated;
  assign out_o.string_end   = res_q.string_end;

  // checks
  `ASSERT_IMPL(a_idle_no_depth, clk_i, rst_ni, (mode_q == ngt_pkg::MODE_IDLE || mode_q == ngt_pkg::MODE_WORD), (depth_q == '0), "depth left over outside a group")
  `ASSERT_IMPL(a_group_depth, clk_i, rst_ni, (mode_q == ngt_pkg::MODE_PAREN || mode_q == ngt_pkg::MODE_CURLY || mode_q == ngt_pkg::MODE_SQUARE), (depth_q != '0), "open group with zero depth")
  `ASSERT_NEXT(a_last_resets, clk_i, rst_ni, (in_acc && in_i.last), (mode_q == ngt_pkg::MODE_IDLE && !bs_q && out_valid_q), "state not cleared after end of string")
  `ASSERT_IMPL(a_no_char_zero, clk_i, rst_ni, (out_valid_q && !res_q.has_char), (res_q.char_out == '0 && !res_q.token_start), "empty beat carries a character")

endmodule

### bench/tag_check_pkg.sv
// ----------------------------------------------------------------------------
// tag_check_pkg
// Expected token tags of the group tokenizer and their check
// ----------------------------------------------------------------------------
// tag_scoreboard tracks its own copy of the scanner (mode, nesting depth,
// backslash flag). Each accepted character adds the tags it should cause to
// a queue, and each result beat is checked field by field against the oldest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tag_check_pkg;

  import ngt_pkg::*;

  localparam int DEPTH_BITS = 8;

  // token separators: space and tab through carriage return
  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  class tag_scoreboard;
    scan_mode_e            mode;
    logic [DEPTH_BITS-1:0] depth;
    logic                  bs_seen;
    result_t               tags_due[$];
    int unsigned           errors;
    int unsigned           tags_noted;

    function new();
      clear_state();
      errors     = 0;
      tags_noted = 0;
    endfunction

    function void clear_state();
      mode    = MODE_IDLE;
      depth   = '0;
      bs_seen = 1'b0;
    endfunction

    function int unsigned pending();
      return tags_due.size();
    endfunction

    // advance the scanner by one accepted character and queue its tags
    function void take_char(input logic [7:0] c, input logic lst);
      result_t    r;
      logic       esc;
      logic       closed;
      logic       keep;
      logic [7:0] op;
      logic [7:0] cl;
      esc     = bs_seen;
      bs_seen = (c == CH_BSLASH);
      r       = '0;
      r.string_end = lst;
      keep    = 1'b1;
      closed  = 1'b0;
      op      = CH_LPAREN;
      cl      = CH_RPAREN;
      case (mode)
        MODE_IDLE: begin
          if (is_blank(c)) begin
            // dropped unless it ends the string
            keep = lst;
          end else begin
            case (c)
              CH_LPAREN: begin
                r.token_kind = KIND_PAREN;
                mode = MODE_PAREN;
              end
              CH_LCURLY: begin
                r.token_kind = KIND_CURLY;
                mode = MODE_CURLY;
              end
              CH_LSQUARE: begin
                r.token_kind = KIND_SQUARE;
                mode = MODE_SQUARE;
              end
              CH_DQUOTE: begin
                r.token_kind = KIND_DQUOTE;
                mode = MODE_DQ;
              end
              CH_SQUOTE: begin
                r.token_kind = KIND_SQUOTE;
                mode = MODE_SQ;
              end
              default: begin
                r.token_kind = KIND_WORD;
                mode = MODE_WORD;
              end
            endcase
            depth = (mode == MODE_PAREN || mode == MODE_CURLY || mode == MODE_SQUARE)
                    ? DEPTH_BITS'(1) : '0;
            r.char_out     = c;
            r.has_char     = 1'b1;
            r.token_start  = 1'b1;
            r.token_end    = lst;
            r.unterminated = lst && (r.token_kind != KIND_WORD);
          end
        end
        MODE_WORD: begin
          if (is_blank(c)) begin
            r.token_end = 1'b1;
            mode = MODE_IDLE;
          end else begin
            r.char_out  = c;
            r.has_char  = 1'b1;
            r.token_end = lst;
          end
        end
        MODE_PAREN, MODE_CURLY, MODE_SQUARE: begin
          case (mode)
            MODE_PAREN: begin
              r.token_kind = KIND_PAREN;
            end
            MODE_CURLY: begin
              op = CH_LCURLY;
              cl = CH_RCURLY;
              r.token_kind = KIND_CURLY;
            end
            default: begin
              op = CH_LSQUARE;
              cl = CH_RSQUARE;
              r.token_kind = KIND_SQUARE;
            end
          endcase
          // own-kind brackets nest unless escaped; depth saturates
          if (!esc && c == op) begin
            if (depth != '1) depth = depth + 1'b1;
          end else if (!esc && c == cl) begin
            if (depth != '0) depth = depth - 1'b1;
            closed = (depth == '0);
          end
          r.char_out     = c;
          r.has_char     = 1'b1;
          r.token_end    = closed || lst;
          r.unterminated = !closed && lst;
          if (closed) begin
            mode  = MODE_IDLE;
            depth = '0;
          end
        end
        default: begin
          // quoted string, closed by the next matching quote
          r.token_kind   = (mode == MODE_DQ) ? KIND_DQUOTE : KIND_SQUOTE;
          closed         = (c == ((mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE));
          r.char_out     = c;
          r.has_char     = 1'b1;
          r.token_end    = closed || lst;
          r.unterminated = !closed && lst;
          if (closed) mode = MODE_IDLE;
        end
      endcase
      if (keep) begin
        tags_due.push_back(r);
        tags_noted++;
      end
      if (lst) clear_state();
    endfunction

    function void compare(input string name, input int unsigned want,
                          input int unsigned seen);
      if (want != seen) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    // check one result beat against the oldest expected tags
    function void check_tags(input result_t got);
      result_t want;
      if (tags_due.size() == 0) begin
        $display("%0t: result with no expected tags, expected none actual %h",
                 $time, got);
        errors++;
      end else begin
        want = tags_due.pop_front();
        compare("char_out", want.char_out, got.char_out);
        compare("has_char", want.has_char, got.has_char);
        compare("token_start", want.token_start, got.token_start);
        compare("token_end", want.token_end, got.token_end);
        compare("token_kind", int'(want.token_kind), int'(got.token_kind));
        compare("unterminated", want.unterminated, got.unterminated);
        compare("string_end", want.string_end, got.string_end);
      end
    endfunction
  endclass

endpackage

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the nested group tokenizer
// ----------------------------------------------------------------------------
// Feeds short directed scripts (words, nested and escaped groups, quotes,
// unterminated tokens, edge bytes), then random scripts of well-formed
// tokens mixed with noise and one deep group that saturates the depth.
// Both sides idle at random; the receiver once holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import ngt_pkg::*;
  import tag_check_pkg::*;

  localparam int ITEMS          = 900;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT    = 3000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ngt_in_if  in_ch ();
  ngt_out_if res_ch ();

  nested_group_tokenizer #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (res_ch)
  );

  tag_scoreboard sb;
  logic [7:0]    script_q[$];
  result_t       seen_tags;
  int            items_sent = 0;
  bit            quiet   = 1'b0;
  bit            calm    = 1'b0;
  bit            rx_calm = 1'b0;
  bit            hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // stimulus helpers

  function automatic logic [7:0] blank_char();
    int idx;
    idx = $urandom_range(0, 5);
    return (idx == 0) ? CH_SPACE : 8'(8'h08 + idx);
  endfunction

  function automatic bit is_opener(input logic [7:0] c);
    return c == CH_LPAREN || c == CH_LCURLY || c == CH_LSQUARE ||
           c == CH_DQUOTE || c == CH_SQUOTE;
  endfunction

  // non-blank byte, mostly letters; a word start must not open a group
  function automatic logic [7:0] plain_char(input bit first);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 1) == 0) ? 8'(8'h61 + $urandom_range(0, 25))
                                      : 8'($urandom_range(0, 255));
    end while (is_blank(c) || (first && is_opener(c)));
    return c;
  endfunction

  task automatic add_word();
    int n;
    n = $urandom_range(1, 6);
    script_q.push_back(plain_char(1'b1));
    repeat (n - 1) script_q.push_back(plain_char(1'b0));
  endtask

  // bracket group with nested and escaped brackets of its own kind
  task automatic add_group(input logic [7:0] op, input logic [7:0] cl,
                           input bit open_end);
    int         d;
    int         n;
    int         pick;
    logic [7:0] c;
    script_q.push_back(op);
    d = 1;
    n = 0;
    while (d > 0 && n < 14) begin
      pick = $urandom_range(0, 9);
      if (pick < 2 && d < 5) begin
        script_q.push_back(op);
        d++;
      end else if (pick < 4) begin
        script_q.push_back(cl);
        d--;
      end else if (pick == 4) begin
        script_q.push_back(CH_BSLASH);
        script_q.push_back(($urandom_range(0, 1) == 0) ? op : cl);
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == op || c == cl || c == CH_BSLASH);
        script_q.push_back(c);
      end
      n++;
    end
    if (!open_end) begin
      while (d > 0) begin
        script_q.push_back(cl);
        d--;
      end
    end
  endtask

  task automatic add_quote(input logic [7:0] q, input bit open_end);
    logic [7:0] c;
    script_q.push_back(q);
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(0, 255));
      while (c == q);
      script_q.push_back(c);
    end
    if (!open_end) script_q.push_back(q);
  endtask

  // mostly well-formed token sequences, sometimes raw noise
  task automatic build_random_script();
    int  ntok;
    bit  open_end;
    bit  after_word;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 20)) script_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) script_q.push_back(blank_char());
      ntok = $urandom_range(1, 5);
      after_word = 1'b0;
      for (int i = 0; i < ntok; i++) begin
        open_end = (i == ntok - 1) && ($urandom_range(0, 7) == 0);
        if (i > 0 && (after_word || $urandom_range(0, 1) == 0))
          repeat ($urandom_range(1, 2)) script_q.push_back(blank_char());
        after_word = 1'b0;
        case ($urandom_range(0, 5))
          0: begin
            add_word();
            after_word = 1'b1;
          end
          1: add_group(CH_LPAREN, CH_RPAREN, open_end);
          2: add_group(CH_LCURLY, CH_RCURLY, open_end);
          3: add_group(CH_LSQUARE, CH_RSQUARE, open_end);
          4: add_quote(CH_DQUOTE, open_end);
          default: add_quote(CH_SQUOTE, open_end);
        endcase
      end
      if ($urandom_range(0, 3) == 0) script_q.push_back(blank_char());
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side

  task automatic send_char(input logic [7:0] c, input logic lst);
    if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    in_ch.last    <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.take_char(c, lst);
    items_sent++;
  endtask

  // whole script as one string, last set on its final character
  task automatic send_script();
    for (int i = 0; i < script_q.size(); i++)
      send_char(script_q[i], i == script_q.size() - 1);
    script_q.delete();
  endtask

  // sender pauses until every expected result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i);
    while (sb.pending() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, one long hold-off on request

  initial begin : rx_side
    int stall_left;
    int span;
    stall_left = 0;
    span = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      span++;
      if (span % 100 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (!quiet && !rx_calm && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      seen_tags.char_out     = res_ch.char_out;
      seen_tags.has_char     = res_ch.has_char;
      seen_tags.token_start  = res_ch.token_start;
      seen_tags.token_end    = res_ch.token_end;
      seen_tags.token_kind   = token_kind_e'(res_ch.token_kind);
      seen_tags.unterminated = res_ch.unterminated;
      seen_tags.string_end   = res_ch.string_end;
      sb.check_tags(seen_tags);
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("FAIL nested_group_tokenizer");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin : main_seq
    bit hold_done;
    bit deep_done;
    sb = new();
    hold_done = 1'b0;
    deep_done = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= '0;
    in_ch.last    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // blank before a word, zero and top bytes, bracket inside a word,
    // word ended by a blank that ends the string
    script_q = '{CH_SPACE, 8'h00, CH_LPAREN, 8'hFF, CH_TAB};
    send_script();
    // nested curly with escaped close, group then quote with no gap,
    // string ending inside an open double quote
    script_q = '{CH_LCURLY, 8'h78, CH_LCURLY, CH_BSLASH, CH_RCURLY, CH_RCURLY,
                 CH_RCURLY, CH_SQUOTE, 8'h61, CH_SQUOTE, CH_DQUOTE, 8'h62};
    send_script();
    // other-kind bracket inside a square group, group opened by last char
    script_q = '{CH_LSQUARE, CH_RPAREN, CH_RSQUARE, CH_LPAREN};
    send_script();
    // word ended by a blank, then a lone blank at end of string
    script_q = '{8'h62, CH_SPACE, CH_CR};
    send_script();
    drain();

    // random scripts
    while (items_sent < ITEMS) begin
      calm  = ($urandom_range(0, 3) == 0);
      quiet = (items_sent > ITEMS - 120);
      if (!hold_done && items_sent > 200) begin
        // receiver holds off while the sender keeps offering
        hold_req  = 1'b1;
        hold_done = 1'b1;
        calm      = 1'b1;
        while (script_q.size() < 20) build_random_script();
        send_script();
      end else if (!deep_done && items_sent > 400) begin
        // nesting past the depth limit, then the surplus closers form a word
        deep_done = 1'b1;
        repeat (260) script_q.push_back(CH_LPAREN);
        repeat (259) script_q.push_back(CH_RPAREN);
        script_q.push_back(CH_SPACE);
        send_script();
      end else begin
        build_random_script();
        send_script();
      end
      if (!quiet && $urandom_range(0, 15) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS nested_group_tokenizer");
    end else begin
      $display("FAIL nested_group_tokenizer");
    end
    $finish;
  end

endmodule
